### rtl/core/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
package brf_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_FLUSH   = 2'd2;
  localparam logic [1:0] FUNC_ADVANCE = 2'd3;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int CNT_W   = 10;
  localparam int CFG_W   = 11;

  // Length register value after reset.
  localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;

  // Input and result payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Status of one request after its operation.
  typedef struct packed {
    logic             rd_ok;
    logic             err;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] cu;
    logic [CNT_W-1:0] cf;
  } brf_status_t;

endpackage

### rtl/core/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: request and result registers around the ring logic.
//
//  channel | direction | sideband        | payload
//  in_     | slave     | tuser = func    | tdata = data_byte, advance_count
//  out_    | master    | none            | tdata = status and read byte
//  cfg_    | slave     | none            | data = length_in_use
//
// One request is taken every cycle while the result is not stalled; after acceptance it passes
// the request register and then the result register before its result is presented.
// The rate is set by the single pointer update and the one read port of the store.
// Reset clears the pointers and sets the length to 1024 (or DEPTH if smaller).
// The byte store is not cleared; there is no clearing pass after reset.
// A stalled result holds both registers and backs pressure up to in_tready.
module byte_ring_fifo_unit
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] data_byte, [23:8] advance_count
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] read_data, [17:8] bytes_used, [27:18] bytes_free, [37:28] contig_used,
  // [47:38] contig_free, [48] is_full, [49] is_empty, [50] op_error, [55:51] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic                in_valid_r;
  logic [FUNC_W-1:0]   func_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [COUNT_W-1:0]  count_r;
  logic                out_valid_r;
  brf_status_t         st_r;
  brf_status_t         st;
  logic                adv;
  logic                fire;
  logic                mem_we;
  logic [PW-1:0]       mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]   mem_q;
  logic [BYTE_W-1:0]   read_data;

  // Stage handshake.
  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r  <= in_tuser;
      byte_r  <= in_tdata[7:0];
      count_r <= in_tdata[23:8];
    end
  end

  brf_ptr #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .LW    (LW)
  ) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_len   (cfg_data),
    .op_fire   (fire),
    .op_func   (func_r),
    .op_count  (count_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .st        (st)
  );

  brf_mem #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (byte_r),
    .re    (fire),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_r <= st;
    end
  end

  // Only a successful read shows the stored byte.
  assign read_data  = st_r.rd_ok ? mem_q : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, st_r.err, st_r.empty, st_r.full, st_r.cf, st_r.cu,
                       st_r.free, st_r.used, read_data};

`ifndef SYNTHESIS
  // A failed request never returns a stored byte.
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r.err |-> st_r.rd_ok == 1'b0)
    else $error("errored request flagged as successful read");
  // Full and empty never hold together.
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(st_r.full && st_r.empty))
    else $error("ring reported full and empty at once");
  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");
`endif

endmodule

### rtl/core/brf_mem.sv
// Byte storage of the ring with one write port and a registered read port.
module brf_mem #(
  parameter int DEPTH = 1024,
  parameter int PW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [PW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while the result waits.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/brf_ptr.sv
// Pointer and length registers with the per-request operation and status logic.
module brf_ptr
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int PW    = 10,
  parameter int LW    = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [CFG_W-1:0]   cfg_len,
  input  logic               op_fire,
  input  logic [FUNC_W-1:0]  op_func,
  input  logic [COUNT_W-1:0] op_count,
  output logic               mem_we,
  output logic [PW-1:0]      mem_waddr,
  output logic [PW-1:0]      mem_raddr,
  output brf_status_t        st
);

  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam logic [LW-1:0] LEN_RST =
    (int'(LEN_RESET) > DEPTH) ? LW'(DEPTH) : LW'(LEN_RESET);

  logic [PW-1:0] rp_r, wp_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_eff;

  logic [LW-1:0] rp_x, wp_x, rp1, wp1, used0, cnt_c, rp_adv;
  logic [LW:0]   adv_sum;
  logic          full0, empty0;
  logic [LW-1:0] rp_n, wp_n;
  logic          we_c, rd_ok_c, err_c;
  logic [LW-1:0] used_n, free_n, cu_n, cf_n;
  logic [CW-1:0] used_x, free_x, cu_x, cf_x;

  // Written length saturated to the range 2 to DEPTH.
  always_comb begin
    if (cfg_len < 11'd2) begin
      len_eff = LW'(2);
    end else if (32'(cfg_len) > 32'(DEPTH)) begin
      len_eff = LW'(DEPTH);
    end else begin
      len_eff = LW'(cfg_len);
    end
  end

  // Status before the operation and the candidate pointer moves.
  always_comb begin
    rp_x    = LW'(rp_r);
    wp_x    = LW'(wp_r);
    rp1     = ((rp_x + 1'b1) == len_r) ? '0 : rp_x + 1'b1;
    wp1     = ((wp_x + 1'b1) == len_r) ? '0 : wp_x + 1'b1;
    full0   = (wp1 == rp_x);
    empty0  = (wp_x == rp_x);
    used0   = (wp_x >= rp_x) ? wp_x - rp_x : len_r - (rp_x - wp_x);
    cnt_c   = (32'(op_count) > 32'(used0)) ? used0 : LW'(op_count);
    adv_sum = {1'b0, rp_x} + {1'b0, cnt_c};
    rp_adv  = (adv_sum >= {1'b0, len_r}) ? LW'(adv_sum - {1'b0, len_r}) : LW'(adv_sum);
  end

  // Operation select.
  always_comb begin
    rp_n    = rp_x;
    wp_n    = wp_x;
    we_c    = 1'b0;
    rd_ok_c = 1'b0;
    err_c   = 1'b0;
    case (op_func)
      FUNC_WRITE: begin
        if (full0) begin
          err_c = 1'b1;
        end else begin
          we_c = 1'b1;
          wp_n = wp1;
        end
      end
      FUNC_READ: begin
        if (empty0) begin
          err_c = 1'b1;
        end else begin
          rd_ok_c = 1'b1;
          rp_n    = rp1;
        end
      end
      FUNC_FLUSH: begin
        rp_n = wp_x;
      end
      FUNC_ADVANCE: begin
        rp_n = rp_adv;
      end
      default: begin
        rp_n = rp_x;
      end
    endcase
  end

  // Status after the operation.
  always_comb begin
    used_n = (wp_n >= rp_n) ? wp_n - rp_n : len_r - (rp_n - wp_n);
    free_n = len_r - 1'b1 - used_n;
    cu_n   = (wp_n >= rp_n) ? wp_n - rp_n : len_r - rp_n;
    if (rp_n > wp_n) begin
      cf_n = rp_n - wp_n - 1'b1;
    end else begin
      cf_n = len_r - wp_n - ((rp_n == '0) ? LW'(1) : LW'(0));
    end
    used_x = CW'(used_n);
    free_x = CW'(free_n);
    cu_x   = CW'(cu_n);
    cf_x   = CW'(cf_n);
  end

  assign st.rd_ok = rd_ok_c;
  assign st.err   = err_c;
  assign st.full  = ((((wp_n + 1'b1) == len_r) ? '0 : wp_n + 1'b1) == rp_n);
  assign st.empty = (wp_n == rp_n);
  assign st.used  = used_x[CNT_W-1:0];
  assign st.free  = free_x[CNT_W-1:0];
  assign st.cu    = cu_x[CNT_W-1:0];
  assign st.cf    = cf_x[CNT_W-1:0];

  assign mem_we    = op_fire && we_c;
  assign mem_waddr = wp_r;
  assign mem_raddr = rp_r;

  // Pointer and length registers; a length write restarts the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      len_r <= LEN_RST;
    end else if (cfg_wr) begin
      rp_r  <= '0;
      wp_r  <= '0;
      len_r <= len_eff;
    end else if (op_fire) begin
      rp_r  <= PW'(rp_n);
      wp_r  <= PW'(wp_n);
    end
  end

`ifndef SYNTHESIS
  // Both pointers stay inside the ring in use.
  a_rp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(rp_r) < len_r) else $error("read pointer beyond ring length");
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(wp_r) < len_r) else $error("write pointer beyond ring length");
  // An accepted write moves the write pointer.
  a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && !cfg_wr |=> wp_r != $past(wp_r))
    else $error("accepted write did not advance write pointer");
`endif

endmodule
